[rtl/core/gbnhs_pkg.sv]
// ----------------------------------------------------------------------------
// gbnhs_pkg: shared types and constants of the grid bucket nearest hook search
// Field widths, item mode and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package gbnhs_pkg;

	// Field widths
	localparam int COORD_W = 16;
	localparam int KIND_W  = 9;
	localparam int EKIND_W = 8;
	localparam int OID_W   = 16;
	localparam int TNUM_W  = 10;
	localparam int OFF_W   = 13;
	localparam int EIDX_W  = 12;
	localparam int DIST_W  = 34;
	localparam int STAT_W  = 2;
	localparam int GRID_W  = 6;
	localparam int MODE_W  = 2;
	localparam int CIDX_W  = 1;

	// Parameter defaults
	localparam int DEF_MAX_ENTRIES = 4096;
	localparam int DEF_MAX_TILES   = 1024;
	localparam int DEF_TILE_COUNTS = 160;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_OFFSET = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	localparam logic [STAT_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL        = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD_OFFSETS = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_Q_AREA,
		ST_Q_CHK,
		ST_Q_HX,
		ST_Q_HY,
		ST_Q_HT,
		ST_Q_RANGE,
		ST_T_IDX,
		ST_T_RD0,
		ST_T_RD1,
		ST_T_CHK,
		ST_E_TEST,
		ST_E_DX,
		ST_E_DY,
		ST_E_CMP
	} state_t;

endpackage

[rtl/core/gbnhs_ram.sv]
// ----------------------------------------------------------------------------
// gbnhs_ram: generic single write port, single read port RAM
// One write and one registered read per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module gbnhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/core/grid_bucket_nearest_hook_search.sv]
// ----------------------------------------------------------------------------
// grid_bucket_nearest_hook_search: nearest anchor entry over a 3x3 tile area
// Keeps an entry table bucketed by grid tile and answers nearest-entry queries.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   ---------------------     ------------------------------------------
//  item in   start & !busy             mode, pos_x, pos_y, hook_kind, object_id,
//                                      tile_number, end_offset
//  result    done (one-cycle strobe)   found, entry_index, distance_sq, status
//  config    cfg_wr_en                 cfg_index, cfg_data (grid width / height)
//
//  Append and tile offset write: result strobed the cycle after the item is taken.
//  Clear: a sweep over the tile end memory, then result.
//  Query: setup, then per scanned tile an index and two tile end reads, per entry
//  a kind/owner test and, on a match, the distance; up to nine tiles. The shared
//  18x18 multiplier and the single read port of the entry RAM make this serial.
//  Reset runs the same clearing sweep with busy high and no result.
//  Results cannot be stalled: done is high for exactly one cycle.
//
module grid_bucket_nearest_hook_search #(
	parameter int MAX_ENTRIES = gbnhs_pkg::DEF_MAX_ENTRIES,
	parameter int MAX_TILES   = gbnhs_pkg::DEF_MAX_TILES,
	parameter int TILE_COUNTS = gbnhs_pkg::DEF_TILE_COUNTS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item in
	input  logic                               start,
	output logic                               busy,
	input  logic [gbnhs_pkg::MODE_W-1:0]       mode,
	input  logic signed [gbnhs_pkg::COORD_W-1:0] pos_x,
	input  logic signed [gbnhs_pkg::COORD_W-1:0] pos_y,
	input  logic signed [gbnhs_pkg::KIND_W-1:0]  hook_kind,
	input  logic [gbnhs_pkg::OID_W-1:0]        object_id,
	input  logic [gbnhs_pkg::TNUM_W-1:0]       tile_number,
	input  logic [gbnhs_pkg::OFF_W-1:0]        end_offset,
	// result
	output logic                               done,
	output logic                               found,
	output logic [gbnhs_pkg::EIDX_W-1:0]       entry_index,
	output logic [gbnhs_pkg::DIST_W-1:0]       distance_sq,
	output logic [gbnhs_pkg::STAT_W-1:0]       status,
	// configuration
	input  logic                               cfg_wr_en,
	input  logic [gbnhs_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [gbnhs_pkg::GRID_W-1:0]       cfg_data
);

	import gbnhs_pkg::*;

	// Entry store and tile end memory geometry
	localparam int EW     = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int TW     = $clog2(MAX_TILES);
	localparam int CMP_W  = (CNT_W > OFF_W) ? CNT_W : OFF_W;
	localparam int ENT_W  = 2 * COORD_W + EKIND_W + OID_W;

	// Home tile by reciprocal multiply: floor(p / TILE_COUNTS) for 0 <= p < 2^15
	// is exact with shift 15 + ceil(log2 TILE_COUNTS) and a rounded-up multiplier.
	localparam int HT_SHIFT = (COORD_W - 1) + $clog2(TILE_COUNTS);
	localparam longint HT_MUL = ((longint'(1) << HT_SHIFT) + TILE_COUNTS - 1) / TILE_COUNTS;

	localparam int MUL_W = 18;
	localparam int PRD_W = 2 * MUL_W;
	localparam int SQ_W  = 32;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [GRID_W-1:0]        grid_w_q, grid_h_q;
	logic [CNT_W-1:0]         count_q;
	logic [TW-1:0]            clr_q;
	logic                     clr_report_q;

	logic signed [COORD_W-1:0] px_q, py_q;
	logic signed [KIND_W-1:0]  kind_q;
	logic [OID_W-1:0]          oid_q;

	logic signed [PRD_W-1:0]  mul_q;
	logic [SQ_W-1:0]          acc_q;
	logic signed [COORD_W:0]  dy_q;

	logic [GRID_W-1:0]        tx_q, ty_q, x0_q, x1_q, y1_q, cur_x_q, cur_y_q;
	logic [TW-1:0]            t_q;
	logic [OFF_W-1:0]         first_q, last_q, scan_q;

	logic                     have_q;
	logic [DIST_W-1:0]        best_q;
	logic [EIDX_W-1:0]        best_idx_q;

	logic                     done_q, found_q;
	logic [EIDX_W-1:0]        idx_q;
	logic [DIST_W-1:0]        dist_q;
	logic [STAT_W-1:0]        status_q;

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	logic              ent_we;
	logic [EW-1:0]     ent_waddr, ent_raddr;
	logic [ENT_W-1:0]  ent_wdata, ent_rdata;

	logic              tile_we;
	logic [TW-1:0]     tile_waddr, tile_raddr;
	logic [OFF_W-1:0]  tile_wdata, tile_rdata;

	gbnhs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_ENTRIES)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ent_we),
		.wr_addr (ent_waddr),
		.wr_data (ent_wdata),
		.rd_addr (ent_raddr),
		.rd_data (ent_rdata)
	);

	gbnhs_ram #(
		.WIDTH(OFF_W),
		.DEPTH(MAX_TILES)
	) u_tile_ram (
		.clk     (clk),
		.wr_en   (tile_we),
		.wr_addr (tile_waddr),
		.wr_data (tile_wdata),
		.rd_addr (tile_raddr),
		.rd_data (tile_rdata)
	);

	// ------------------------------------------------------------------
	// Decode of the item and of the entry under scan
	// ------------------------------------------------------------------
	mode_t                    mode_in;
	logic                     accept;
	logic                     table_full;
	logic                     tile_in_range;

	logic signed [COORD_W-1:0] e_x, e_y;
	logic [EKIND_W-1:0]       e_kind;
	logic [OID_W-1:0]         e_occ;
	logic                     e_match;
	logic signed [COORD_W:0]  dx;

	logic                     grid_bad, kind_bad, bucket_bad;
	logic [TW-1:0]            t_cur;
	logic                     last_tile;
	logic [DIST_W-1:0]        dist_sum;

	logic signed [MUL_W-1:0]  mul_a, mul_b;

	assign mode_in       = mode_t'(mode);
	assign accept        = start && (state_q == ST_IDLE);
	assign table_full    = count_q >= CNT_W'(MAX_ENTRIES);
	assign tile_in_range = int'(tile_number) < MAX_TILES;

	assign {e_x, e_y, e_kind, e_occ} = ent_rdata;

	// Wrong kind or taken by someone other than the excluded id: skip
	assign e_match = ((kind_q == -9'sd1) || ($signed({1'b0, e_kind}) == kind_q))
		&& ((e_occ == '0) || (e_occ == oid_q));
	assign dx = $signed({e_x[COORD_W-1], e_x}) - $signed({px_q[COORD_W-1], px_q});

	assign grid_bad = (grid_w_q == '0) || (grid_h_q == '0)
		|| ($unsigned(mul_q) > PRD_W'(MAX_TILES));
	assign kind_bad = kind_q < -9'sd1;

	assign bucket_bad = (first_q > tile_rdata) || (CMP_W'(tile_rdata) > CMP_W'(count_q));

	assign t_cur     = TW'(mul_q) + TW'(cur_x_q);
	assign last_tile = (cur_x_q == x1_q) && (cur_y_q == y1_q);
	assign dist_sum  = DIST_W'(acc_q) + DIST_W'(mul_q[SQ_W-1:0]);

	// Clamp a reciprocal product to the home tile within [0, cnt - 1]
	function automatic logic [GRID_W-1:0] clamp_tile(
		input logic signed [PRD_W-1:0] prod,
		input logic [GRID_W-1:0]       cnt
	);
		logic [PRD_W-1:0] q;
		q = $unsigned(prod) >> HT_SHIFT;
		if (q > PRD_W'(cnt - 1'b1)) begin
			return cnt - 1'b1;
		end
		return GRID_W'(q);
	endfunction

	// ------------------------------------------------------------------
	// Shared multiplier: grid area, home tile, tile row base, dx^2, dy^2
	// ------------------------------------------------------------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_Q_AREA: begin
				mul_a = MUL_W'(grid_w_q);
				mul_b = MUL_W'(grid_h_q);
			end
			ST_Q_HX: begin
				// negative coordinates floor below zero: clamp to the first tile
				mul_a = px_q[COORD_W-1] ? '0 : MUL_W'(px_q);
				mul_b = MUL_W'(HT_MUL);
			end
			ST_Q_HY: begin
				mul_a = py_q[COORD_W-1] ? '0 : MUL_W'(py_q);
				mul_b = MUL_W'(HT_MUL);
			end
			ST_T_IDX: begin
				mul_a = MUL_W'(cur_y_q);
				mul_b = MUL_W'(grid_w_q);
			end
			ST_E_DX: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'(dx);
			end
			ST_E_DY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// ------------------------------------------------------------------
	// Memory port steering
	// ------------------------------------------------------------------
	always_comb begin
		ent_we     = accept && (mode_in == MODE_APPEND) && !table_full;
		ent_waddr  = EW'(count_q);
		ent_wdata  = {pos_x, pos_y, hook_kind[EKIND_W-1:0], object_id};
		ent_raddr  = EW'(scan_q);

		tile_we    = 1'b0;
		tile_waddr = TW'(tile_number);
		tile_wdata = end_offset;
		if (state_q == ST_CLR) begin
			tile_we    = 1'b1;
			tile_waddr = clr_q;
			tile_wdata = '0;
		end else if (accept && (mode_in == MODE_OFFSET) && tile_in_range) begin
			tile_we = 1'b1;
		end

		// previous tile end first (bucket start), then this tile end
		tile_raddr = (state_q == ST_T_RD0) ? TW'(t_cur - TW'(1)) : t_q;
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode_in)
						MODE_CLEAR: state_d = ST_CLR;
						MODE_QUERY: state_d = ST_Q_AREA;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLR: begin
				if (clr_q == TW'(MAX_TILES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_Q_AREA:  state_d = ST_Q_CHK;
			ST_Q_CHK:   state_d = (grid_bad || kind_bad) ? ST_IDLE : ST_Q_HX;
			ST_Q_HX:    state_d = ST_Q_HY;
			ST_Q_HY:    state_d = ST_Q_HT;
			ST_Q_HT:    state_d = ST_Q_RANGE;
			ST_Q_RANGE: state_d = ST_T_IDX;
			ST_T_IDX:   state_d = ST_T_RD0;
			ST_T_RD0:   state_d = ST_T_RD1;
			ST_T_RD1:   state_d = ST_T_CHK;
			ST_T_CHK:   state_d = bucket_bad ? ST_IDLE : ST_E_TEST;
			ST_E_TEST: begin
				if (scan_q < last_q) begin
					state_d = ST_E_DX;
				end else if (last_tile) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_T_IDX;
				end
			end
			ST_E_DX:  state_d = e_match ? ST_E_DY : ST_E_TEST;
			ST_E_DY:  state_d = ST_E_CMP;
			ST_E_CMP: state_d = ST_E_TEST;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers: grid size, entry count, clear sweep, result strobe
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q     <= GRID_W'(1);
			grid_h_q     <= GRID_W'(1);
			count_q      <= '0;
			clr_q        <= '0;
			clr_report_q <= 1'b0;
			have_q       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;

			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_GRID_WIDTH:  grid_w_q <= cfg_data;
					CFG_GRID_HEIGHT: grid_h_q <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (mode_in)
							MODE_CLEAR: begin
								count_q      <= '0;
								clr_q        <= '0;
								clr_report_q <= 1'b1;
							end
							MODE_APPEND: begin
								done_q <= 1'b1;
								if (!table_full) begin
									count_q <= count_q + 1'b1;
								end
							end
							default: begin
								// offset writes answer at once; queries answer later
								done_q <= (mode_in == MODE_OFFSET);
							end
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TW'(MAX_TILES - 1)) begin
						done_q       <= clr_report_q;
						clr_report_q <= 1'b0;
					end
				end
				ST_Q_CHK: begin
					done_q <= grid_bad || kind_bad;
				end
				ST_Q_RANGE: begin
					have_q <= 1'b0;
				end
				ST_T_CHK: begin
					done_q <= bucket_bad;
				end
				ST_E_TEST: begin
					done_q <= (scan_q >= last_q) && last_tile;
				end
				ST_E_CMP: begin
					if (!have_q || (dist_sum < best_q)) begin
						have_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers: latched item, tile walk, bucket scan, best entry
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q   <= pos_x;
				py_q   <= pos_y;
				kind_q <= hook_kind;
				oid_q  <= object_id;
				// every item except a query answers with zeros but for these
				found_q  <= 1'b0;
				idx_q    <= '0;
				dist_q   <= '0;
				status_q <= STATUS_OK;
				if (mode_in == MODE_APPEND) begin
					if (table_full) begin
						status_q <= STATUS_FULL;
					end else begin
						idx_q <= EIDX_W'(count_q);
					end
				end
			end
			ST_CLR: begin
				found_q  <= 1'b0;
				idx_q    <= '0;
				dist_q   <= '0;
				status_q <= STATUS_OK;
			end
			ST_Q_CHK: begin
				// bad grid reports an error; a kind below "any" just misses
				status_q <= grid_bad ? STATUS_BAD_OFFSETS : STATUS_OK;
			end
			ST_Q_HY: begin
				tx_q <= clamp_tile(mul_q, grid_w_q);
			end
			ST_Q_HT: begin
				ty_q <= clamp_tile(mul_q, grid_h_q);
			end
			ST_Q_RANGE: begin
				// clip the 3x3 neighborhood to the grid
				x0_q    <= (tx_q != '0) ? tx_q - 1'b1 : '0;
				cur_x_q <= (tx_q != '0) ? tx_q - 1'b1 : '0;
				cur_y_q <= (ty_q != '0) ? ty_q - 1'b1 : '0;
				x1_q <= ((GRID_W + 1)'(tx_q) + 1'b1 < (GRID_W + 1)'(grid_w_q))
					? tx_q + 1'b1 : grid_w_q - 1'b1;
				y1_q <= ((GRID_W + 1)'(ty_q) + 1'b1 < (GRID_W + 1)'(grid_h_q))
					? ty_q + 1'b1 : grid_h_q - 1'b1;
			end
			ST_T_RD0: begin
				t_q <= t_cur;
			end
			ST_T_RD1: begin
				first_q <= (t_q == '0) ? '0 : tile_rdata;
			end
			ST_T_CHK: begin
				scan_q   <= first_q;
				last_q   <= tile_rdata;
				// a bad bucket drops any candidate found so far
				found_q  <= 1'b0;
				idx_q    <= '0;
				dist_q   <= '0;
				status_q <= STATUS_BAD_OFFSETS;
			end
			ST_E_TEST: begin
				if ((scan_q >= last_q) && !last_tile) begin
					// advance row-major through the neighborhood
					if (cur_x_q == x1_q) begin
						cur_x_q <= x0_q;
						cur_y_q <= cur_y_q + 1'b1;
					end else begin
						cur_x_q <= cur_x_q + 1'b1;
					end
				end
				found_q  <= have_q;
				idx_q    <= have_q ? best_idx_q : '0;
				dist_q   <= have_q ? best_q : '0;
				status_q <= STATUS_OK;
			end
			ST_E_DX: begin
				dy_q <= $signed({e_y[COORD_W-1], e_y}) - $signed({py_q[COORD_W-1], py_q});
				if (!e_match) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			ST_E_DY: begin
				acc_q <= mul_q[SQ_W-1:0];
			end
			ST_E_CMP: begin
				// strictly nearer only: the first entry found keeps a tie
				if (!have_q || (dist_sum < best_q)) begin
					best_q     <= dist_sum;
					best_idx_q <= EIDX_W'(scan_q);
				end
				scan_q <= scan_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs
	// ------------------------------------------------------------------
	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign found       = found_q;
	assign entry_index = idx_q;
	assign distance_sq = dist_q;
	assign status      = status_q;

endmodule

[bench/nearest_hook_checker.sv]
// ----------------------------------------------------------------------------
// nearest_hook_checker: result prediction and comparison for the hook search
// Watches the item, result and register channels, keeps its own copy of the
// anchor table and grid size, and compares every result with the oldest one
// predicted.
// ----------------------------------------------------------------------------
module nearest_hook_checker
	import gbnhs_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [MODE_W-1:0]         mode,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [KIND_W-1:0]  hook_kind,
	input  logic [OID_W-1:0]          object_id,
	input  logic [TNUM_W-1:0]         tile_number,
	input  logic [OFF_W-1:0]          end_offset,
	input  logic                      done,
	input  logic                      found,
	input  logic [EIDX_W-1:0]         entry_index,
	input  logic [DIST_W-1:0]         distance_sq,
	input  logic [STAT_W-1:0]         status,
	input  logic                      cfg_wr_en,
	input  logic [CIDX_W-1:0]         cfg_index,
	input  logic [GRID_W-1:0]         cfg_data,
	output int                        pending,
	output int                        fail_count
);

	localparam int N_ENTRIES = DEF_MAX_ENTRIES;
	localparam int N_TILES   = DEF_MAX_TILES;
	localparam int TILE      = DEF_TILE_COUNTS;

	typedef struct packed {
		logic              found;
		logic [EIDX_W-1:0] index;
		logic [DIST_W-1:0] dist_sq;
		logic [STAT_W-1:0] status;
	} answer_t;

	logic signed [COORD_W-1:0] anchor_x     [N_ENTRIES];
	logic signed [COORD_W-1:0] anchor_y     [N_ENTRIES];
	logic [EKIND_W-1:0]        anchor_kind  [N_ENTRIES];
	logic [OID_W-1:0]          anchor_owner [N_ENTRIES];
	logic [OFF_W-1:0]          bucket_end   [N_TILES];
	int                        anchor_count;
	int                        cols;
	int                        rows;
	answer_t                   answers_due [$];
	int                        errors;

	// floor division into tiles, clamped into the grid
	function automatic int home_tile(int p, int span);
		int q;
		q = p / TILE;
		if (p % TILE != 0 && p < 0)
			q--;
		if (q < 0)
			q = 0;
		if (q > span - 1)
			q = span - 1;
		return q;
	endfunction

	function automatic answer_t nearest_anchor(int px, int py, int kind_sel,
			logic [OID_W-1:0] excl);
		answer_t a;
		int tx, ty, x0, x1, y0, y1, x, y, i, t, first, last, ek;
		longint dx, dy, d, best;
		bit have;
		int best_at;
		a = '0;
		have = 1'b0;
		best = 0;
		best_at = 0;
		if (cols <= 0 || rows <= 0 || cols * rows > N_TILES) begin
			a.status = STATUS_BAD_OFFSETS;
			return a;
		end
		if (kind_sel < -1)
			return a;
		tx = home_tile(px, cols);
		ty = home_tile(py, rows);
		y0 = (ty > 0) ? ty - 1 : 0;
		y1 = (ty + 1 < rows) ? ty + 1 : rows - 1;
		x0 = (tx > 0) ? tx - 1 : 0;
		x1 = (tx + 1 < cols) ? tx + 1 : cols - 1;
		for (y = y0; y <= y1; y++) begin
			for (x = x0; x <= x1; x++) begin
				t = y * cols + x;
				first = (t == 0) ? 0 : int'(bucket_end[t-1]);
				last = int'(bucket_end[t]);
				// a bad bucket aborts the whole search
				if (first > last || last > anchor_count) begin
					a = '0;
					a.status = STATUS_BAD_OFFSETS;
					return a;
				end
				for (i = first; i < last; i++) begin
					ek = int'(anchor_kind[i]);
					if (kind_sel != -1 && ek != kind_sel)
						continue;
					if (anchor_owner[i] != '0 && anchor_owner[i] != excl)
						continue;
					dx = longint'(anchor_x[i]) - px;
					dy = longint'(anchor_y[i]) - py;
					d = dx * dx + dy * dy;
					if (!have || d < best) begin
						have = 1'b1;
						best = d;
						best_at = i;
					end
				end
			end
		end
		if (have) begin
			a.found = 1'b1;
			a.index = EIDX_W'(best_at);
			a.dist_sq = DIST_W'(best);
		end
		return a;
	endfunction

	function automatic void match(string field, logic [DIST_W-1:0] exp_v,
			logic [DIST_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, field,
				exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t due;
		answer_t want;
		if (!arst_n) begin
			anchor_count = 0;
			foreach (bucket_end[t])
				bucket_end[t] = '0;
			cols = 1;
			rows = 1;
			answers_due.delete();
			errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			// compare before queueing: a result never belongs to this edge's item
			if (done) begin
				if (answers_due.size() == 0) begin
					$display("%0t unexpected result: expected none, %s %0d %0d %0d %0d",
						$time, "actual found/index/dist/status", found, entry_index,
						distance_sq, status);
					errors++;
				end else begin
					want = answers_due.pop_front();
					match("found", DIST_W'(want.found), DIST_W'(found));
					match("entry_index", DIST_W'(want.index), DIST_W'(entry_index));
					match("distance_sq", want.dist_sq, distance_sq);
					match("status", DIST_W'(want.status), DIST_W'(status));
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == CFG_GRID_WIDTH)
					cols = int'(cfg_data);
				else
					rows = int'(cfg_data);
			end
			if (start && !busy) begin
				due = '0;
				case (mode_t'(mode))
					MODE_CLEAR: begin
						anchor_count = 0;
						foreach (bucket_end[t])
							bucket_end[t] = '0;
					end
					MODE_APPEND: begin
						if (anchor_count >= N_ENTRIES) begin
							due.status = STATUS_FULL;
						end else begin
							anchor_x[anchor_count] = pos_x;
							anchor_y[anchor_count] = pos_y;
							anchor_kind[anchor_count] = hook_kind[EKIND_W-1:0];
							anchor_owner[anchor_count] = object_id;
							due.index = EIDX_W'(anchor_count);
							anchor_count++;
						end
					end
					MODE_OFFSET: begin
						bucket_end[tile_number] = end_offset;
					end
					MODE_QUERY: begin
						due = nearest_anchor(int'(pos_x), int'(pos_y), int'(hook_kind),
							object_id);
					end
					default: ;
				endcase
				answers_due = {answers_due, due};
			end
			pending <= answers_due.size();
			fail_count <= errors;
		end
	end

endmodule

[bench/tb_grid_bucket_nearest_hook_search.sv]
// ----------------------------------------------------------------------------
// tb_grid_bucket_nearest_hook_search: stimulus and verdict for the hook search
// Drives directed and random item streams plus grid size writes into the
// block; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_grid_bucket_nearest_hook_search;
	import gbnhs_pkg::*;

	// Watchdog bound for the whole run; keep a wide margin.
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 1500;
	// The last items of the random part go through back to back, with no idle gaps.
	localparam int CALM_ITEMS   = 200;
	// Drain time after the last result, so that a stray result strobe is still seen.
	localparam int SETTLE       = 40;
	localparam int TILE         = DEF_TILE_COUNTS;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [MODE_W-1:0]         mode;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [KIND_W-1:0]  hook_kind;
	logic [OID_W-1:0]          object_id;
	logic [TNUM_W-1:0]         tile_number;
	logic [OFF_W-1:0]          end_offset;
	logic                      done;
	logic                      found;
	logic [EIDX_W-1:0]         entry_index;
	logic [DIST_W-1:0]         distance_sq;
	logic [STAT_W-1:0]         status;
	logic                      cfg_wr_en;
	logic [CIDX_W-1:0]         cfg_index;
	logic [GRID_W-1:0]         cfg_data;

	int pending;
	int fail_count;
	int cycles;
	int items_sent;
	int calm_from;
	int gap_odds;

	grid_bucket_nearest_hook_search i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.hook_kind   (hook_kind),
		.object_id   (object_id),
		.tile_number (tile_number),
		.end_offset  (end_offset),
		.done        (done),
		.found       (found),
		.entry_index (entry_index),
		.distance_sq (distance_sq),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	nearest_hook_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.hook_kind   (hook_kind),
		.object_id   (object_id),
		.tile_number (tile_number),
		.end_offset  (end_offset),
		.done        (done),
		.found       (found),
		.entry_index (entry_index),
		.distance_sq (distance_sq),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends up here.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Drive one item at the current edge and hold it until the block takes it.
	// Called at a rising edge; returns at the edge that accepted the item, so the
	// next call can raise start again in the same step without dropping it.
	task automatic push_item(mode_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [KIND_W-1:0] kind, logic [OID_W-1:0] oid, logic [TNUM_W-1:0] tnum,
			logic [OFF_W-1:0] eoff);
		mode <= op;
		pos_x <= x;
		pos_y <= y;
		hook_kind <= kind;
		object_id <= oid;
		tile_number <= tnum;
		end_offset <= eoff;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		// Idle in short bursts, except in the closing stretch.
		if (items_sent < calm_from && gap_odds != 0 &&
				$urandom_range(1, 2 * gap_odds) == 1) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Unused fields of each mode get random bits so that every bit toggles.
	task automatic wipe();
		push_item(MODE_CLEAR, COORD_W'($urandom), COORD_W'($urandom), KIND_W'($urandom),
			OID_W'($urandom), TNUM_W'($urandom), OFF_W'($urandom));
	endtask

	task automatic add_entry(int x, int y, int kind, int owner);
		push_item(MODE_APPEND, COORD_W'(x), COORD_W'(y), KIND_W'(kind), OID_W'(owner),
			TNUM_W'($urandom), OFF_W'($urandom));
	endtask

	task automatic set_end(int tile, int offset);
		push_item(MODE_OFFSET, COORD_W'($urandom), COORD_W'($urandom), KIND_W'($urandom),
			OID_W'($urandom), TNUM_W'(tile), OFF_W'(offset));
	endtask

	task automatic ask(int x, int y, int kind, int excl);
		push_item(MODE_QUERY, COORD_W'(x), COORD_W'(y), KIND_W'(kind), OID_W'(excl),
			TNUM_W'($urandom), OFF_W'($urandom));
	endtask

	// Hold off until the block is idle and every predicted result has arrived.
	// Check only after an edge has passed: pending is registered and lags the acceptance.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	// Grid size writes happen only with the block idle.
	task automatic set_grid(int w, int h);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data <= GRID_W'(w);
		@(posedge clk);
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data <= GRID_W'(h);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Extreme grid extents: empty, minimal, largest legal, just past, field max.
	function automatic int pick_extent();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 1;
			2: return 32;
			3: return 33;
			default: return 63;
		endcase
	endfunction

	// Kinds cluster on a few values so that filters hit; -1 is "any" on a query
	// and stores as 255 on an append; the full 9-bit range shows up now and then.
	function automatic int pick_kind(int any_weight);
		if ($urandom_range(0, 9) < any_weight)
			return -1;
		case ($urandom_range(0, 7))
			0: return 255;
			1: return $urandom_range(0, 511);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	// Mostly free entries; a few small ids so that exclusion matches occur.
	function automatic int pick_owner();
		case ($urandom_range(0, 9))
			6, 7, 8: return $urandom_range(1, 3);
			9: return $urandom_range(0, 65535);
			default: return 0;
		endcase
	endfunction

	// Position inside tile column/row c; coarse steps make distance ties likely.
	function automatic int spot_in(int c);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2: return c * TILE + 32 * $urandom_range(0, 4);
			default: return c * TILE + $urandom_range(0, TILE - 1);
		endcase
	endfunction

	// Query position over the grid span plus a margin on each side.
	function automatic int scan_spot(int span);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2: return 32 * $urandom_range(0, span * 5 + 2) - 32;
			default: return $urandom_range(0, span * TILE + 400) - 200;
		endcase
	endfunction

	// One well-formed table: clear, fill tile buckets in order with their end
	// offsets, then mostly queries with some stray offset writes and items.
	// Big or illegal grids only get their first few tiles filled.
	task automatic bucket_session(int w, int h);
		int tw, th, nt, t, n, total;
		tw = (w == 0) ? 1 : w;
		th = (h == 0) ? 1 : h;
		nt = w * h;
		if (nt == 0 || nt > 36)
			nt = $urandom_range(1, 8);
		wipe();
		total = 0;
		for (t = 0; t < nt; t++) begin
			n = $urandom_range(0, 3);
			repeat (n) begin
				add_entry(spot_in(t % tw), spot_in(t / tw), pick_kind(1), pick_owner());
				total++;
			end
			set_end(t, total);
		end
		repeat ($urandom_range(8, 30)) begin
			case ($urandom_range(0, 19))
				0: set_end($urandom_range(0, 1023), $urandom_range(0, 8191));
				1: push_item(mode_t'($urandom_range(0, 3)), COORD_W'($urandom),
					COORD_W'($urandom), KIND_W'($urandom), OID_W'($urandom),
					TNUM_W'($urandom), OFF_W'($urandom));
				default: ask(scan_spot(tw), scan_spot(th), pick_kind(4), pick_owner());
			endcase
		end
	endtask

	initial begin : stimulus
		int w, h, session, stop_at;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_CLEAR;
		pos_x = '0;
		pos_y = '0;
		hook_kind = '0;
		object_id = '0;
		tile_number = '0;
		end_offset = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_GRID_WIDTH;
		cfg_data = '0;
		items_sent = 0;
		calm_from = 32'h7fff_ffff;
		gap_odds = 0;
		w = 1;
		h = 1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table on the reset grid of one tile.
		ask(0, 0, -1, 0);

		// Directed table on a 2x2 grid, so every query's neighborhood covers all four buckets.
		set_grid(2, 2);
		wipe();
		add_entry(-32768, -32768, -1, 0);
		add_entry(32767, 32767, 254, 16'hffff);
		add_entry(0, 0, 0, 5);
		add_entry(100, 100, -256, 0);
		set_end(0, 2);
		set_end(1, 3);
		set_end(2, 4);
		set_end(3, 4);
		ask(32767, 32767, -1, 0);           // occupied entries skipped
		ask(-32768, -32768, -1, 0);         // exact hit at the far corner
		ask(32767, 32767, 255, 0);          // largest distance, kind stored from -1
		ask(32767, 32767, 254, 16'hffff);   // occupant equals the exclude id
		ask(50, 50, 0, 5);                  // tie: the lower index wins
		ask(50, 50, 0, 0);
		ask(-32768, -32768, -2, 0);         // kind below any: no match
		ask(0, 0, -256, 0);
		ask(0, 0, 7, 0);                    // kind absent from the table
		set_end(1023, 0);
		set_end(3, 8191);                   // bucket runs past the entry count
		ask(0, 0, -1, 0);
		set_end(3, 3);                      // bucket start above its end
		ask(0, 0, -1, 0);

		// Random part: the first sessions take the grid corners, then mostly
		// small grids with an occasional extreme one.
		calm_from = items_sent + RANDOM_ITEMS - CALM_ITEMS;
		stop_at = items_sent + RANDOM_ITEMS;
		session = 0;
		while (items_sent < stop_at) begin
			// the closing stretch keeps the last grid: no pause for a register write
			if (items_sent < calm_from) begin
				case (session)
					0: begin w = 32; h = 32; end
					1: begin w = 1; h = 1; end
					2: begin w = 0; h = 5; end
					3: begin w = 5; h = 0; end
					4: begin w = 63; h = 63; end
					5: begin w = 33; h = 32; end
					default: begin
						if ($urandom_range(0, 9) == 0) begin
							w = pick_extent();
							h = pick_extent();
						end else begin
							w = $urandom_range(1, 6);
							h = $urandom_range(1, 6);
						end
					end
				endcase
				gap_odds = $urandom_range(0, 3);
				set_grid(w, h);
			end
			bucket_session(w, h);
			session++;
		end

		settle();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
